>>> design/json_string_unescape_utf8_assert.svh
// Assertion macros used by the checker of the JSON string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json_string_unescape_utf8: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json_string_unescape_utf8: next-cycle check failed");

`endif

>>> design/jsu_pkg.sv
// Types, codes and helper functions of the JSON string unescaper.
package jsu_pkg;

    localparam int MaxRes = 4;

    typedef struct packed {
        logic [7:0] ch;
        logic       text_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [3:0] err_code;
        logic       last;
    } t_out;

    typedef struct packed {
        t_out [MaxRes-1:0] res;
        logic [2:0]        cnt;
    } t_grp;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_BODY  = 4'd1,
        PH_ESC   = 4'd2,
        PH_HEX1  = 4'd3,
        PH_LOWBS = 4'd4,
        PH_LOWU  = 4'd5,
        PH_HEX2  = 4'd6
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  hex_count;
        logic [15:0] unit_accum;
        logic [9:0]  high_bits;
    } t_state;

    localparam logic [1:0] K_DATA   = 2'd0;
    localparam logic [1:0] K_CLOSED = 2'd1;
    localparam logic [1:0] K_ERROR  = 2'd2;

    localparam logic [3:0] E_NONE     = 4'd0;
    localparam logic [3:0] E_NOQUOTE  = 4'd1;
    localparam logic [3:0] E_CONTROL  = 4'd2;
    localparam logic [3:0] E_BADESC   = 4'd3;
    localparam logic [3:0] E_BADHEX   = 4'd4;
    localparam logic [3:0] E_NOLOWESC = 4'd5;
    localparam logic [3:0] E_BADLOW   = 4'd6;
    localparam logic [3:0] E_LONELOW  = 4'd7;
    localparam logic [3:0] E_UNTERM   = 4'd8;

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChLowB   = 8'h62;
    localparam logic [7:0] ChLowF   = 8'h66;
    localparam logic [7:0] ChLowN   = 8'h6E;
    localparam logic [7:0] ChLowR   = 8'h72;
    localparam logic [7:0] ChLowT   = 8'h74;
    localparam logic [7:0] ChLowU   = 8'h75;
    localparam logic [7:0] ChSpace  = 8'h20;

    localparam logic [20:0] SuppBase = 21'h10000;

    // Returns {found, nibble}, where nibble is the value of the hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

>>> design/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper that turns string literals into UTF-8 bytes.
//
// Input channel: one raw text byte per request (ch, text_end) on i_in_valid and
// o_in_stall. The block waits for an opening quote, then decodes the string body.
// Output channel: one result per request on o_out_valid and i_out_stall: a data
// byte, a closed marker or an error with its code; last marks the final result
// that one input byte caused.
// A request accepted into the input register is decoded into the result group
// register once that register frees up, and its results are offered from then on.
// Throughput: one input byte per cycle while every byte gives at most one result
// and the receiver does not stall. A \uXXXX escape that yields k UTF-8 bytes holds
// the result group register until all k are taken, so the input side stalls
// meanwhile; the result group register hands them out one at a time.
// Reset clears the decoder state (waiting for a quote), the input register valid
// and the result group count; no result is offered after reset.
// When the receiver stalls, the offered result holds steady; the input register
// keeps one byte in reserve and then o_in_stall rises until results drain.
module json_string_unescape_utf8 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  jsu_pkg::t_in   i_in,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output jsu_pkg::t_out  o_out
);

    jsu_pkg::t_in    r_in;
    logic            r_in_valid;
    jsu_pkg::t_state r_state;
    jsu_pkg::t_state n_state;
    jsu_pkg::t_grp   n_grp;
    logic            grp_free;
    logic            in_move;

    // The buffered byte is decoded when the result group register frees up.
    assign in_move    = r_in_valid && grp_free;
    assign o_in_stall = r_in_valid && !in_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (in_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    // Decoder state advances only when a byte is actually decoded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= jsu_pkg::PH_IDLE;
            r_state.hex_count  <= 3'd0;
            r_state.unit_accum <= 16'd0;
            r_state.high_bits  <= 10'd0;
        end else if (in_move) begin
            r_state <= n_state;
        end
    end

    jsu_decode u_decode (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_grp   (n_grp)
    );

    jsu_out_seq u_out_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_move),
        .i_grp   (n_grp),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (o_out),
        .o_free  (grp_free)
    );

endmodule

>>> design/jsu_decode.sv
// Combinational decode of one raw byte into next state and up to four results.
module jsu_decode (
    input  jsu_pkg::t_state i_state,
    input  jsu_pkg::t_in    i_item,
    output jsu_pkg::t_state o_state,
    output jsu_pkg::t_grp   o_grp
);

    logic [4:0]  hex;
    logic [15:0] acc;

    assign hex = jsu_pkg::hex_val(i_item.ch);
    assign acc = {i_state.unit_accum[11:0], hex[3:0]};

    always_comb begin
        logic        do_fail;
        logic [3:0]  f_code;
        logic        do_close;
        logic        do_byte;
        logic [7:0]  byte_v;
        logic        do_cp;
        logic [20:0] cp;
        logic [7:0]  ch;
        logic        fin;

        do_fail  = 1'b0;
        f_code   = jsu_pkg::E_NONE;
        do_close = 1'b0;
        do_byte  = 1'b0;
        byte_v   = 8'd0;
        do_cp    = 1'b0;
        cp       = 21'd0;
        ch       = i_item.ch;
        fin      = i_item.text_end;
        o_state  = i_state;
        o_grp    = '0;

        unique case (i_state.phase)
            jsu_pkg::PH_BODY: begin
                if (fin) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_UNTERM;
                end else if (ch == jsu_pkg::ChQuote) begin
                    do_close = 1'b1;
                end else if (ch == jsu_pkg::ChBslash) begin
                    o_state.phase = jsu_pkg::PH_ESC;
                end else if (ch < jsu_pkg::ChSpace) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_CONTROL;
                end else begin
                    do_byte = 1'b1;
                    byte_v  = ch;
                end
            end
            jsu_pkg::PH_ESC: begin
                if (fin) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_UNTERM;
                end else begin
                    o_state.phase = jsu_pkg::PH_BODY;
                    do_byte       = 1'b1;
                    unique case (ch)
                        jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash: begin
                            byte_v = ch;
                        end
                        jsu_pkg::ChLowB: byte_v = 8'h08;
                        jsu_pkg::ChLowF: byte_v = 8'h0C;
                        jsu_pkg::ChLowN: byte_v = 8'h0A;
                        jsu_pkg::ChLowR: byte_v = 8'h0D;
                        jsu_pkg::ChLowT: byte_v = 8'h09;
                        jsu_pkg::ChLowU: begin
                            do_byte            = 1'b0;
                            o_state.phase      = jsu_pkg::PH_HEX1;
                            o_state.hex_count  = 3'd0;
                            o_state.unit_accum = 16'd0;
                        end
                        default: begin
                            do_byte = 1'b0;
                            do_fail = 1'b1;
                            f_code  = jsu_pkg::E_BADESC;
                        end
                    endcase
                end
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                if (fin) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_UNTERM;
                end else if (!hex[4]) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_BADHEX;
                end else if (i_state.hex_count != 3'd3) begin
                    o_state.unit_accum = acc;
                    o_state.hex_count  = i_state.hex_count + 3'd1;
                end else begin
                    // Fourth digit: the code unit is complete.
                    o_state.hex_count  = 3'd0;
                    o_state.unit_accum = 16'd0;
                    if (i_state.phase == jsu_pkg::PH_HEX1) begin
                        if (acc[15:10] == 6'b110110) begin
                            o_state.high_bits = acc[9:0];
                            o_state.phase     = jsu_pkg::PH_LOWBS;
                        end else if (acc[15:10] == 6'b110111) begin
                            do_fail = 1'b1;
                            f_code  = jsu_pkg::E_LONELOW;
                        end else begin
                            o_state.phase = jsu_pkg::PH_BODY;
                            do_cp         = 1'b1;
                            cp            = {5'd0, acc};
                        end
                    end else begin
                        if (acc[15:10] != 6'b110111) begin
                            do_fail = 1'b1;
                            f_code  = jsu_pkg::E_BADLOW;
                        end else begin
                            o_state.phase     = jsu_pkg::PH_BODY;
                            o_state.high_bits = 10'd0;
                            do_cp             = 1'b1;
                            cp = {1'b0, i_state.high_bits, acc[9:0]} + jsu_pkg::SuppBase;
                        end
                    end
                end
            end
            jsu_pkg::PH_LOWBS: begin
                if (fin) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_UNTERM;
                end else if (ch != jsu_pkg::ChBslash) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_NOLOWESC;
                end else begin
                    o_state.phase = jsu_pkg::PH_LOWU;
                end
            end
            jsu_pkg::PH_LOWU: begin
                if (fin) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_UNTERM;
                end else if (ch != jsu_pkg::ChLowU) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_NOLOWESC;
                end else begin
                    o_state.phase      = jsu_pkg::PH_HEX2;
                    o_state.hex_count  = 3'd0;
                    o_state.unit_accum = 16'd0;
                end
            end
            default: begin
                // Waiting for the opening quote; unused phase codes behave the same.
                if (fin || ch != jsu_pkg::ChQuote) begin
                    do_fail = 1'b1;
                    f_code  = jsu_pkg::E_NOQUOTE;
                end else begin
                    o_state       = '0;
                    o_state.phase = jsu_pkg::PH_BODY;
                end
            end
        endcase

        if (do_fail || do_close) begin
            o_state       = '0;
            o_state.phase = jsu_pkg::PH_IDLE;
            o_grp.cnt     = 3'd1;
            o_grp.res[0].kind     = do_fail ? jsu_pkg::K_ERROR : jsu_pkg::K_CLOSED;
            o_grp.res[0].err_code = do_fail ? f_code : jsu_pkg::E_NONE;
        end else if (do_byte) begin
            o_grp.cnt             = 3'd1;
            o_grp.res[0].out_byte = byte_v;
        end else if (do_cp) begin
            if (cp[20:7] == 14'd0) begin
                o_grp.cnt             = 3'd1;
                o_grp.res[0].out_byte = cp[7:0];
            end else if (cp[20:11] == 10'd0) begin
                o_grp.cnt             = 3'd2;
                o_grp.res[0].out_byte = {3'b110, cp[10:6]};
                o_grp.res[1].out_byte = {2'b10, cp[5:0]};
            end else if (cp[20:16] == 5'd0) begin
                o_grp.cnt             = 3'd3;
                o_grp.res[0].out_byte = {4'b1110, cp[15:12]};
                o_grp.res[1].out_byte = {2'b10, cp[11:6]};
                o_grp.res[2].out_byte = {2'b10, cp[5:0]};
            end else begin
                o_grp.cnt             = 3'd4;
                o_grp.res[0].out_byte = {5'b11110, cp[20:18]};
                o_grp.res[1].out_byte = {2'b10, cp[17:12]};
                o_grp.res[2].out_byte = {2'b10, cp[11:6]};
                o_grp.res[3].out_byte = {2'b10, cp[5:0]};
            end
        end

        for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
            o_grp.res[i].last = (o_grp.cnt == 3'(i + 1));
        end
    end

endmodule

>>> design/jsu_out_seq.sv
// Result group register that hands out the decoded results one per cycle while the receiver does not stall.
module jsu_out_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  jsu_pkg::t_grp  i_grp,
    input  logic           i_stall,
    output logic           o_valid,
    output jsu_pkg::t_out  o_res,
    output logic           o_free
);

    jsu_pkg::t_out [jsu_pkg::MaxRes-1:0] r_res;
    logic [2:0]                          r_cnt;
    logic [1:0]                          r_idx;
    logic                                take;
    logic                                done;

    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_res[r_idx];
    assign take    = o_valid && !i_stall;
    assign done    = take && ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign o_free  = !o_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_grp.cnt;
            r_idx <= 2'd0;
        end else if (done) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_grp.res;
        end
    end

endmodule

>>> design/jsu_checker.sv
// Port-level checker of the JSON string unescaper and its bind statement.
`include "json_string_unescape_utf8_assert.svh"

module jsu_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input jsu_pkg::t_out o_out
);

    logic out_held;
    logic out_marker;
    logic out_is_err;
    logic out_has_code;

    assign out_held     = o_out_valid && i_out_stall;
    assign out_marker   = o_out_valid && (o_out.kind != jsu_pkg::K_DATA);
    assign out_is_err   = (o_out.kind == jsu_pkg::K_ERROR);
    assign out_has_code = (o_out.err_code != jsu_pkg::E_NONE);

    // A stalled result stays offered and unchanged.
    `JSU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(o_out))

    // Closed and error results always end the results of their input byte.
    `JSU_ASSERT_IMPL(a_end_is_last, i_clk, i_rst_n, out_marker, o_out.last)

    // An error code is present exactly on error results.
    `JSU_ASSERT_IMPL(a_err_code, i_clk, i_rst_n, o_out_valid, out_is_err == out_has_code)

    // Results other than data carry a zero byte.
    `JSU_ASSERT_IMPL(a_zero_byte, i_clk, i_rst_n, out_marker, o_out.out_byte == 8'd0)

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

>>> verif/tb_json_string_unescape_utf8.sv
// Self-checking testbench for the JSON string unescaper, driven with string literals byte by byte.
module tb_json_string_unescape_utf8;

    // The run is stopped by force if it takes longer than this many cycles.
    localparam int unsigned CycleLimit   = 500000;
    // The receiver holds off this long in the backpressure test.
    localparam int unsigned LongHold     = 300;
    // Upper bound on the wait for outstanding results at the end of the run.
    localparam int unsigned DrainLimit   = 20000;
    // A request passes the input and result group registers before its first result
    // can be taken, so these quiet cycles after the last result catch a stray extra one.
    localparam int unsigned SettleCycles = 10;
    localparam int unsigned MaxReports   = 10;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    jsu_pkg::t_in  i_in;
    logic          o_in_stall;
    logic          o_out_valid;
    logic          i_out_stall;
    jsu_pkg::t_out o_out;

    // Decoder state as the testbench tracks it, updated on every accepted request.
    jsu_pkg::t_phase dec_phase;
    logic [2:0]      dec_digits;
    logic [15:0]     dec_unit;
    logic [9:0]      dec_high;

    // Results of the request being decoded, then the ordered list of all
    // results still owed by the block.
    jsu_pkg::t_out step_res[$];
    jsu_pkg::t_out utf8_expected[$];
    // Text bytes waiting to be sent.
    jsu_pkg::t_in  text_q[$];

    int unsigned bytes_sent   = 0;
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    bit          src_idle_on  = 1'b0;
    bit          sink_idle_on = 1'b0;
    bit          hold_pending = 1'b0;

    json_string_unescape_utf8 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // Every error and every closed string returns the decoder to waiting for
    // an opening quote with all partial escape state dropped.
    function automatic void clear_decoder();
        dec_phase  = jsu_pkg::PH_IDLE;
        dec_digits = 3'd0;
        dec_unit   = 16'd0;
        dec_high   = 10'd0;
    endfunction

    function automatic void add_result(input logic [7:0] b, input logic [1:0] k,
                                       input logic [3:0] e);
        step_res.push_back('{out_byte: b, kind: k, err_code: e, last: 1'b0});
    endfunction

    function automatic void decode_fail(input logic [3:0] e);
        clear_decoder();
        add_result(8'h00, jsu_pkg::K_ERROR, e);
    endfunction

    function automatic void add_data(input logic [7:0] b);
        add_result(b, jsu_pkg::K_DATA, jsu_pkg::E_NONE);
    endfunction

    // Splits a code point into its UTF-8 bytes, one result per byte.
    function automatic void add_code_point(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            add_data(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            add_data({3'b110, cp[10:6]});
            add_data({2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            add_data({4'b1110, cp[15:12]});
            add_data({2'b10, cp[11:6]});
            add_data({2'b10, cp[5:0]});
        end else begin
            add_data({5'b11110, cp[20:18]});
            add_data({2'b10, cp[17:12]});
            add_data({2'b10, cp[11:6]});
            add_data({2'b10, cp[5:0]});
        end
    endfunction

    // Returns the digit value in the low four bits and a found flag on top.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else begin
            return 5'd0;
        end
        return {1'b1, d[3:0]};
    endfunction

    // Handles a byte while waiting for the opening quote.
    function automatic void wait_quote(input jsu_pkg::t_in req);
        if (req.text_end || req.ch != jsu_pkg::ChQuote) decode_fail(jsu_pkg::E_NOQUOTE);
        else dec_phase = jsu_pkg::PH_BODY;
    endfunction

    // Decodes one accepted request and appends the results it owes.
    task automatic unescape_step(input jsu_pkg::t_in req);
        logic [4:0]  nv;
        logic [15:0] cu;
        step_res.delete();
        nv = nibble_of(req.ch);
        case (dec_phase)
            jsu_pkg::PH_IDLE: begin
                wait_quote(req);
            end
            jsu_pkg::PH_BODY: begin
                if (req.text_end) begin
                    decode_fail(jsu_pkg::E_UNTERM);
                end else if (req.ch == jsu_pkg::ChQuote) begin
                    clear_decoder();
                    add_result(8'h00, jsu_pkg::K_CLOSED, jsu_pkg::E_NONE);
                end else if (req.ch == jsu_pkg::ChBslash) begin
                    dec_phase = jsu_pkg::PH_ESC;
                end else if (req.ch < jsu_pkg::ChSpace) begin
                    decode_fail(jsu_pkg::E_CONTROL);
                end else begin
                    add_data(req.ch);
                end
            end
            jsu_pkg::PH_ESC: begin
                if (req.text_end) begin
                    decode_fail(jsu_pkg::E_UNTERM);
                end else begin
                    dec_phase = jsu_pkg::PH_BODY;
                    case (req.ch)
                        jsu_pkg::ChQuote, jsu_pkg::ChBslash, jsu_pkg::ChSlash: begin
                            add_data(req.ch);
                        end
                        jsu_pkg::ChLowB: add_data(8'h08);
                        jsu_pkg::ChLowF: add_data(8'h0C);
                        jsu_pkg::ChLowN: add_data(8'h0A);
                        jsu_pkg::ChLowR: add_data(8'h0D);
                        jsu_pkg::ChLowT: add_data(8'h09);
                        jsu_pkg::ChLowU: begin
                            dec_phase  = jsu_pkg::PH_HEX1;
                            dec_digits = 3'd0;
                            dec_unit   = 16'd0;
                        end
                        default: decode_fail(jsu_pkg::E_BADESC);
                    endcase
                end
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                if (req.text_end) begin
                    decode_fail(jsu_pkg::E_UNTERM);
                end else if (!nv[4]) begin
                    decode_fail(jsu_pkg::E_BADHEX);
                end else begin
                    dec_unit   = {dec_unit[11:0], nv[3:0]};
                    dec_digits = dec_digits + 3'd1;
                    if (dec_digits == 3'd4) begin
                        dec_digits = 3'd0;
                        cu = dec_unit;
                        if (dec_phase == jsu_pkg::PH_HEX1) begin
                            if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
                                // High half of a pair: park it and look for a low escape.
                                dec_high  = cu[9:0];
                                dec_unit  = 16'd0;
                                dec_phase = jsu_pkg::PH_LOWBS;
                            end else if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
                                decode_fail(jsu_pkg::E_LONELOW);
                            end else begin
                                dec_unit  = 16'd0;
                                dec_phase = jsu_pkg::PH_BODY;
                                add_code_point({5'd0, cu});
                            end
                        end else if (cu < 16'hDC00 || cu > 16'hDFFF) begin
                            decode_fail(jsu_pkg::E_BADLOW);
                        end else begin
                            add_code_point(jsu_pkg::SuppBase + {1'b0, dec_high, cu[9:0]});
                            dec_unit  = 16'd0;
                            dec_high  = 10'd0;
                            dec_phase = jsu_pkg::PH_BODY;
                        end
                    end
                end
            end
            jsu_pkg::PH_LOWBS: begin
                if (req.text_end) decode_fail(jsu_pkg::E_UNTERM);
                else if (req.ch != jsu_pkg::ChBslash) decode_fail(jsu_pkg::E_NOLOWESC);
                else dec_phase = jsu_pkg::PH_LOWU;
            end
            jsu_pkg::PH_LOWU: begin
                if (req.text_end) begin
                    decode_fail(jsu_pkg::E_UNTERM);
                end else if (req.ch != jsu_pkg::ChLowU) begin
                    decode_fail(jsu_pkg::E_NOLOWESC);
                end else begin
                    dec_phase  = jsu_pkg::PH_HEX2;
                    dec_digits = 3'd0;
                    dec_unit   = 16'd0;
                end
            end
            default: begin
                // An unknown phase starts over from the waiting state.
                clear_decoder();
                wait_quote(req);
            end
        endcase
        if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[k]) utf8_expected.push_back(step_res[k]);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_failure(input string what, input jsu_pkg::t_out want,
                                  input jsu_pkg::t_out got);
        fail_count++;
        if (fail_count <= MaxReports)
            $display({"[%0t] %s: expected byte %02h kind %0d err %0d last %0d,",
                      " got byte %02h kind %0d err %0d last %0d"},
                     $time, what, want.out_byte, want.kind, want.err_code, want.last,
                     got.out_byte, got.kind, got.err_code, got.last);
    endtask

    task automatic check_result(input jsu_pkg::t_out got);
        jsu_pkg::t_out want;
        if (utf8_expected.size() == 0) begin
            report_failure("unexpected result", '0, got);
        end else begin
            want = utf8_expected.pop_front();
            if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                got.err_code !== want.err_code || got.last !== want.last)
                report_failure("result mismatch", want, got);
        end
    endtask

    // A result is taken at every rising edge where it is offered and not stalled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result(o_out);
    end

    // ------------------------------------------------------------------
    // Receiver stall: random bursts, plus one long hold when requested
    // ------------------------------------------------------------------

    initial begin : sink_stall
        int unsigned stall_len;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            stall_len = 0;
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_len = LongHold;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                stall_len = $urandom_range(1, 17);
            end
            if (stall_len != 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("json_string_unescape_utf8 test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sending text
    // ------------------------------------------------------------------

    // Called at a falling edge; returns at the falling edge after acceptance,
    // with valid still high so that the next request can follow without a gap.
    task automatic send_byte(input jsu_pkg::t_in req);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        unescape_step(req);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic flush_text();
        while (text_q.size() != 0) send_byte(text_q.pop_front());
    endtask

    function automatic void put_ch(input logic [7:0] c);
        text_q.push_back('{ch: c, text_end: 1'b0});
    endfunction

    // The byte that travels with an end marker is ignored, so it is random.
    function automatic void put_end();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        text_q.push_back('{ch: junk, text_end: 1'b1});
    endfunction

    function automatic void put_str(input string s);
        for (int k = 0; k < s.len(); k++) put_ch(s[k]);
    endfunction

    // Hex letters come out in either case at random.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
    endfunction

    function automatic void put_unit(input logic [15:0] u);
        put_ch(jsu_pkg::ChBslash);
        put_ch(jsu_pkg::ChLowU);
        for (int k = 3; k >= 0; k--) put_ch(hex_char(u[4*k +: 4]));
    endfunction

    function automatic logic [7:0] esc_letter(input int unsigned k);
        case (k)
            0: return jsu_pkg::ChQuote;
            1: return jsu_pkg::ChBslash;
            2: return jsu_pkg::ChSlash;
            3: return jsu_pkg::ChLowB;
            4: return jsu_pkg::ChLowF;
            5: return jsu_pkg::ChLowN;
            6: return jsu_pkg::ChLowR;
            default: return jsu_pkg::ChLowT;
        endcase
    endfunction

    // Builds one string literal with random content. A broken literal gets a
    // fault: a random byte or an end of text at a random point, a pair whose
    // second half is not a low surrogate, a lone low surrogate or a control byte.
    function automatic void put_random_literal(input bit broken);
        int unsigned n_parts;
        int unsigned keep;
        logic [7:0]  c;
        logic [15:0] u;
        n_parts = $urandom_range(0, 6);
        put_ch(jsu_pkg::ChQuote);
        repeat (n_parts) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    c = 8'($urandom_range(8'h20, 8'hFF));
                    if (c == jsu_pkg::ChQuote || c == jsu_pkg::ChBslash) c = 8'h7E;
                    put_ch(c);
                end
                4, 5: begin
                    put_ch(jsu_pkg::ChBslash);
                    put_ch(esc_letter($urandom_range(0, 7)));
                end
                6, 7: begin
                    case ($urandom_range(0, 3))
                        0: u = 16'($urandom_range(16'h0000, 16'h007F));
                        1: u = 16'($urandom_range(16'h0080, 16'h07FF));
                        2: u = 16'($urandom_range(16'h0800, 16'hD7FF));
                        default: u = 16'($urandom_range(16'hE000, 16'hFFFF));
                    endcase
                    put_unit(u);
                end
                default: begin
                    u = 16'($urandom_range(0, 1023));
                    put_unit(16'hD800 | u);
                    u = 16'($urandom_range(0, 1023));
                    put_unit(16'hDC00 | u);
                end
            endcase
        end
        if (!broken) begin
            put_ch(jsu_pkg::ChQuote);
        end else begin
            case ($urandom_range(0, 4))
                0, 1: begin
                    keep = $urandom_range(1, text_q.size());
                    while (text_q.size() > keep) void'(text_q.pop_back());
                    if ($urandom_range(0, 1)) put_end();
                    else put_ch(8'($urandom_range(0, 255)));
                end
                2: begin
                    u = 16'($urandom_range(0, 1023));
                    put_unit(16'hD800 | u);
                    if ($urandom_range(0, 1)) u = 16'($urandom_range(16'h0000, 16'hDBFF));
                    else u = 16'($urandom_range(16'hE000, 16'hFFFF));
                    put_unit(u);
                end
                3: begin
                    u = 16'($urandom_range(0, 1023));
                    put_unit(16'hDC00 | u);
                end
                default: put_ch(8'($urandom_range(8'h00, 8'h1F)));
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Anything but a quote while waiting is rejected, the end of text included.
    task automatic test_outside_string();
        put_end();
        put_ch(8'h78);
        put_ch(8'hFF);
        put_ch(8'h00);
        flush_text();
    endtask

    // Plain bytes at the edges of the allowed range, every one-letter escape,
    // control bytes including zero, and an unknown escape letter.
    task automatic test_simple_escapes();
        put_ch(jsu_pkg::ChQuote);
        put_ch(jsu_pkg::ChSpace);
        put_ch(8'hFF);
        put_ch(8'h7F);
        for (int unsigned k = 0; k < 8; k++) begin
            put_ch(jsu_pkg::ChBslash);
            put_ch(esc_letter(k));
        end
        put_ch(jsu_pkg::ChQuote);
        put_ch(jsu_pkg::ChQuote);
        put_ch(8'h1F);
        put_ch(jsu_pkg::ChQuote);
        put_ch(8'h00);
        put_ch(jsu_pkg::ChQuote);
        put_ch(jsu_pkg::ChBslash);
        put_ch(8'h71);
        flush_text();
    endtask

    // Code units at each UTF-8 length boundary, a zero code unit, mixed-case
    // hex digits, and surrogate pairs at both ends of the supplementary range.
    task automatic test_utf8_widths();
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'h0000);
        put_unit(16'h007F);
        put_unit(16'h0080);
        put_unit(16'h07FF);
        put_unit(16'h0800);
        put_unit(16'hD7FF);
        put_unit(16'hE000);
        put_unit(16'hFFFF);
        put_str("\\uaBcD");
        put_unit(16'hD800);
        put_unit(16'hDC00);
        put_unit(16'hDBFF);
        put_unit(16'hDFFF);
        put_unit(16'hD83D);
        put_unit(16'hDE00);
        put_ch(jsu_pkg::ChQuote);
        flush_text();
    endtask

    // Bad hex digit, lone low half, a high half without a following \u, and
    // a high half followed by a code unit below and above the low range.
    task automatic test_surrogate_errors();
        put_ch(jsu_pkg::ChQuote);
        put_str("\\u12G");
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'hDC00);
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'hD800);
        put_ch(8'h41);
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'hDBFF);
        put_ch(jsu_pkg::ChBslash);
        put_ch(jsu_pkg::ChLowN);
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'hD800);
        put_unit(16'h0041);
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'hDABC);
        put_unit(16'hE000);
        flush_text();
    endtask

    // The text ends in every state inside a string.
    task automatic test_unterminated();
        put_ch(jsu_pkg::ChQuote);
        put_end();
        put_ch(jsu_pkg::ChQuote);
        put_ch(8'h61);
        put_end();
        put_ch(jsu_pkg::ChQuote);
        put_ch(jsu_pkg::ChBslash);
        put_end();
        put_ch(jsu_pkg::ChQuote);
        put_str("\\u1");
        put_end();
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'hD800);
        put_end();
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'hD800);
        put_ch(jsu_pkg::ChBslash);
        put_end();
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'hD800);
        put_str("\\u");
        put_end();
        put_ch(jsu_pkg::ChQuote);
        put_unit(16'hD800);
        put_str("\\uDC0");
        put_end();
        flush_text();
    endtask

    // Mostly well-formed literals with random content, some broken ones and
    // some stray bytes between strings. A literal that is left open by its
    // fault is ended so that the next one starts from the waiting state.
    task automatic test_random_literals(input int unsigned n_bytes);
        int unsigned stop_at;
        logic [7:0]  c;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                c = 8'($urandom_range(0, 255));
                if (c == jsu_pkg::ChQuote) put_end();
                else put_ch(c);
            end else begin
                put_random_literal($urandom_range(0, 3) == 0);
            end
            flush_text();
            if (dec_phase != jsu_pkg::PH_IDLE) begin
                put_end();
                flush_text();
            end
        end
    endtask

    // The receiver holds off for a long time while the sender keeps offering
    // three-byte escapes and plain letters, then a surrogate pair, so the block fills up and stalls its input.
    task automatic test_backpressure();
        bit          saved_idle;
        logic [15:0] u;
        saved_idle   = src_idle_on;
        src_idle_on  = 1'b0;
        hold_pending = 1'b1;
        put_ch(jsu_pkg::ChQuote);
        repeat (12) begin
            u = 16'($urandom_range(16'h0800, 16'hD7FF));
            put_unit(u);
            put_ch(8'h61);
        end
        put_unit(16'hD801);
        put_unit(16'hDC37);
        put_ch(jsu_pkg::ChQuote);
        flush_text();
        src_idle_on = saved_idle;
    endtask

    task automatic wait_for_drain();
        int unsigned waited;
        waited = 0;
        while (utf8_expected.size() != 0 && waited < DrainLimit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SettleCycles) @(posedge i_clk);
        if (utf8_expected.size() != 0)
            report_failure("missing result", utf8_expected[0], '0);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        clear_decoder();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        test_outside_string();
        test_simple_escapes();
        test_utf8_widths();
        test_surrogate_errors();
        test_unterminated();
        test_random_literals(80);
        test_backpressure();

        // The last stretch runs at full rate on both sides, once any receiver
        // burst still in progress has ended.
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (i_out_stall) @(negedge i_clk);
        test_random_literals(40);

        i_in_valid <= 1'b0;
        wait_for_drain();
        if (fail_count == 0) $display("json_string_unescape_utf8 test passed");
        else $display("json_string_unescape_utf8 test failed");
        $finish;
    end

endmodule
